### rtl/core/anct_pkg.sv
// Package for the aging neighbor cell table.
// Holds table sizing, field widths, op and result codes and the sequencer state type.
// No dependencies.
package anct_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int IN_W     = 224;
    localparam int OUT_W    = 96;
    localparam int CFG_IDX_W = 2;

    localparam logic [15:0] STALE_RESET = 16'd2000;
    localparam logic [15:0] SWEEP_RESET = 16'd1000;
    localparam logic [15:0] PORT_RESET  = 16'd4997;
    localparam logic [15:0] NO_SIGNAL   = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_STALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT  = 2'd2;

    localparam logic [2:0] OP_ACK   = 3'd0;
    localparam logic [2:0] OP_MSG   = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_BEST  = 3'd3;
    localparam logic [2:0] OP_ADDR  = 3'd4;

    localparam logic [2:0] KIND_SIGNAL = 3'd0;
    localparam logic [2:0] KIND_LOST   = 3'd1;
    localparam logic [2:0] KIND_FWD    = 3'd2;
    localparam logic [2:0] KIND_BEST   = 3'd3;
    localparam logic [2:0] KIND_ADDR   = 3'd4;
    localparam logic [2:0] KIND_DROP   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINISH,
        S_LOST
    } t_state;

endpackage

### rtl/core/aging_neighbor_cell_table.sv
// Aging neighbor cell table: learn, forward, age out and query neighbor cells.
// After accept, the table is scanned in index order and any result word is loaded in the finish state;
// a tick first checks the period and, only when it sweeps, scans and then walks the table, loading each
// loss word in index order. A new input word is taken only in idle, after the previous op is done; an
// unused op is dropped without a scan, and output stalls hold the finish state and the loss walk.
// Synchronous active-low reset clears valid bits, next cell, last sweep and control, and loads config defaults.
module aging_neighbor_cell_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // op[2:0]
    input  logic [2:0]                    i_s_axis_tuser,
    // station_key[63:0], link_ip[95:64], link_port[111:96],
    // signal_dbm[127:112], now[191:128], cell_number[222:192]
    input  logic [anct_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // kind[2:0]
    output logic [2:0]                    o_m_axis_tuser,
    // cell_number_res[30:0], signal_dbm_res[46:31], found[47],
    // link_ip_res[79:48], link_port_res[95:80]
    output logic [anct_pkg::OUT_W-1:0]    o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [anct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import anct_pkg::*;

    t_state r_state, n_state;

    logic [15:0] r_stale, r_sweep, r_port;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [63:0]        r_station [TABLE_DEPTH];
    logic [30:0]        r_cellv   [TABLE_DEPTH];
    logic [31:0]        r_ip      [TABLE_DEPTH];
    logic [15:0]        r_portv   [TABLE_DEPTH];
    logic signed [15:0] r_level   [TABLE_DEPTH];
    logic [63:0]        r_seen    [TABLE_DEPTH];
    logic [30:0]        r_next_cell;
    logic [63:0]        r_last_sweep;

    logic [2:0]         r_op;
    logic [63:0]        r_key;
    logic [31:0]        r_in_ip;
    logic [15:0]        r_in_port;
    logic signed [15:0] r_in_level;
    logic [63:0]        r_now;
    logic [30:0]        r_in_cell;

    logic [IDX_W-1:0]   r_idx;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hidx;
    logic               r_fhit;
    logic [IDX_W-1:0]   r_fidx;
    logic signed [15:0] r_best;
    logic [30:0]        r_best_cell;
    logic [TABLE_DEPTH-1:0] r_mask;

    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [30:0] r_out_cell;
    logic [15:0] r_out_dbm;
    logic        r_out_found;
    logic [31:0] r_out_ip;
    logic [15:0] r_out_port;
    logic        r_out_last;

    logic w_in_acc, w_out_free, w_scan_last, w_period_ok;
    logic w_ent_v, w_key_match, w_stale, w_best_match, w_cell_match;
    logic w_load;
    logic [2:0]  w_kind;
    logic [30:0] w_cell;
    logic [15:0] w_dbm;
    logic        w_found, w_last;
    logic [31:0] w_ip;
    logic [15:0] w_port;
    logic [TABLE_DEPTH-1:0] w_hi;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_scan_last = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign w_period_ok = (r_now - r_last_sweep) > {48'd0, r_sweep};

    assign w_ent_v      = r_valid[r_idx];
    assign w_key_match  = w_ent_v && (r_station[r_idx] == r_key);
    assign w_stale      = w_ent_v && ((r_now - r_seen[r_idx]) > {48'd0, r_stale});
    assign w_best_match = w_ent_v && (r_ip[r_idx] == r_in_ip) && (r_portv[r_idx] == r_port)
                          && (!r_hit || (r_level[r_idx] >= r_best));
    assign w_cell_match = w_ent_v && (r_cellv[r_idx] == r_in_cell);
    assign w_hi         = r_mask >> r_idx;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_s_axis_tuser)
                        OP_TICK:                  n_state = S_CHECK;
                        OP_ACK, OP_MSG, OP_BEST,
                        OP_ADDR:                  n_state = S_SCAN;
                        default:                  n_state = S_IDLE;
                    endcase
                end
            end
            S_CHECK:  n_state = w_period_ok ? S_SCAN : S_IDLE;
            S_SCAN:   if (w_scan_last) n_state = (r_op == OP_TICK) ? S_LOST : S_FINISH;
            S_FINISH: if (w_out_free) n_state = S_IDLE;
            S_LOST:   if (w_out_free && w_scan_last) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_load  = 1'b0;
        w_kind  = KIND_SIGNAL;
        w_cell  = '0;
        w_dbm   = '0;
        w_found = 1'b0;
        w_ip    = '0;
        w_port  = '0;
        w_last  = 1'b1;
        case (r_state)
            S_FINISH: begin
                case (r_op)
                    OP_ACK: begin
                        w_kind = KIND_SIGNAL;
                        w_dbm  = r_in_level;
                        if (r_hit) begin
                            w_load = (r_level[r_idx] != r_in_level);
                            w_cell = r_cellv[r_idx];
                        end else if (r_fhit) begin
                            w_load = 1'b1;
                            w_cell = r_next_cell + 31'd1;
                        end else begin
                            w_load = 1'b1;
                            w_kind = KIND_DROP;
                            w_dbm  = '0;
                        end
                    end
                    OP_MSG: begin
                        w_load = r_hit;
                        w_kind = KIND_FWD;
                        w_cell = r_cellv[r_idx];
                    end
                    OP_BEST: begin
                        w_load  = 1'b1;
                        w_kind  = KIND_BEST;
                        w_found = r_hit;
                        w_cell  = r_hit ? r_best_cell : '0;
                    end
                    OP_ADDR: begin
                        w_load  = 1'b1;
                        w_kind  = KIND_ADDR;
                        w_found = r_hit;
                        if (r_hit) begin
                            w_cell = r_in_cell;
                            w_ip   = r_ip[r_idx];
                            w_port = r_portv[r_idx];
                        end
                    end
                    default: w_load = 1'b0;
                endcase
            end
            S_LOST: begin
                w_load = r_mask[r_idx];
                w_kind = KIND_LOST;
                w_cell = r_cellv[r_idx];
                w_dbm  = NO_SIGNAL;
                w_last = (w_hi[TABLE_DEPTH-1:1] == '0);
            end
            default: w_load = 1'b0;
        endcase
        w_load = w_load && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_stale      <= STALE_RESET;
            r_sweep      <= SWEEP_RESET;
            r_port       <= PORT_RESET;
            r_valid      <= '0;
            r_next_cell  <= '0;
            r_last_sweep <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_fhit       <= 1'b0;
            r_mask       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STALE: r_stale <= i_cfg_data;
                    CFG_SWEEP: r_sweep <= i_cfg_data;
                    CFG_PORT:  r_port  <= i_cfg_data;
                    default:   r_port  <= r_port;
                endcase
            end
            if (i_m_axis_tready) r_out_valid <= 1'b0;
            if (w_load) r_out_valid <= 1'b1;

            case (r_state)
                S_IDLE: begin
                    r_idx  <= '0;
                    r_hit  <= 1'b0;
                    r_fhit <= 1'b0;
                    r_mask <= '0;
                end
                S_CHECK: if (w_period_ok) r_last_sweep <= r_now;
                S_SCAN: begin
                    r_idx <= w_scan_last ? '0 : r_idx + 1'b1;
                    case (r_op)
                        OP_ACK, OP_MSG: begin
                            if (w_key_match && !r_hit) begin
                                r_hit  <= 1'b1;
                                r_hidx <= r_idx;
                            end
                            if (!w_ent_v && !r_fhit) begin
                                r_fhit <= 1'b1;
                                r_fidx <= r_idx;
                            end
                            if (w_scan_last) begin
                                if (r_hit || w_key_match) r_idx <= (r_hit ? r_hidx : r_idx);
                                else if (r_fhit)          r_idx <= r_fidx;
                                else if (!w_ent_v)        r_idx <= r_idx;
                                if (!r_fhit && !w_ent_v)  r_fhit <= 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (w_stale) begin
                                r_mask[r_idx]  <= 1'b1;
                                r_valid[r_idx] <= 1'b0;
                            end
                        end
                        OP_BEST: begin
                            if (w_best_match) begin
                                r_hit       <= 1'b1;
                                r_best      <= r_level[r_idx];
                                r_best_cell <= r_cellv[r_idx];
                            end
                        end
                        OP_ADDR: begin
                            if (w_cell_match && !r_hit) begin
                                r_hit  <= 1'b1;
                                r_hidx <= r_idx;
                            end
                            if (w_scan_last) r_idx <= r_hit ? r_hidx : r_idx;
                        end
                        default: r_idx <= r_idx;
                    endcase
                end
                S_FINISH: begin
                    if (w_out_free && r_op == OP_ACK && (r_hit || r_fhit)) begin
                        if (!r_hit) begin
                            r_next_cell        <= r_next_cell + 31'd1;
                            r_valid[r_idx]     <= 1'b1;
                            r_station[r_idx]   <= r_key;
                            r_cellv[r_idx]     <= r_next_cell + 31'd1;
                        end
                        r_ip[r_idx]    <= r_in_ip;
                        r_portv[r_idx] <= r_in_port;
                        r_level[r_idx] <= r_in_level;
                        r_seen[r_idx]  <= r_now;
                    end
                end
                S_LOST: if (w_out_free) r_idx <= r_idx + 1'b1;
                default: r_idx <= r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op       <= i_s_axis_tuser;
            r_key      <= i_s_axis_tdata[63:0];
            r_in_ip    <= i_s_axis_tdata[95:64];
            r_in_port  <= i_s_axis_tdata[111:96];
            r_in_level <= i_s_axis_tdata[127:112];
            r_now      <= i_s_axis_tdata[191:128];
            r_in_cell  <= i_s_axis_tdata[222:192];
        end
        if (w_load) begin
            r_out_kind  <= w_kind;
            r_out_cell  <= w_cell;
            r_out_dbm   <= w_dbm;
            r_out_found <= w_found;
            r_out_ip    <= w_ip;
            r_out_port  <= w_port;
            r_out_last  <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {r_out_port, r_out_ip, r_out_found, r_out_dbm, r_out_cell};

    a_next_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_next_cell) |-> $past(r_state) == S_FINISH)
        else $error("next cell moved outside finish");
    a_valid_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) > $past($countones(r_valid)) |-> $past(r_state) == S_FINISH)
        else $error("entry learned outside finish");
    a_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |=> (r_state == S_SCAN || r_state == S_IDLE))
        else $error("bad state after sweep check");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOST && r_out_valid && !i_m_axis_tready) |=> $stable(r_idx))
        else $error("loss walk advanced while stalled");

endmodule
